// ===== rtl/srsym_pkg.sv =====
// ----------------------------------------------------------------------------
// srsym_pkg
// shared types, constants and the alphabet lookup of the radix to symbols unit
// ----------------------------------------------------------------------------
package srsym_pkg;

   localparam int MAX_SYMBOLS_DEF = 16;
   localparam int VALUE_BITS_DEF  = 32;

   localparam int BASE_LEN_W  = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CHAR_W      = 8;
   localparam int TABLE_W     = 2 * CSR_DATA_W;
   localparam int STEP_BITS   = 8;

   localparam logic [CHAR_W-1:0]     CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0]     CHAR_PLUS  = 8'h2B;
   localparam logic [BASE_LEN_W-1:0] MIN_RADIX  = 5'd2;

   localparam logic [BASE_LEN_W-1:0] BASE_LEN_RST     = 5'd10;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_LENGTH  = 2'd0,
      CSR_SYMBOLS_LOW  = 2'd1,
      CSR_SYMBOLS_HIGH = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CHECK,
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   function automatic logic [CHAR_W-1:0] symbol_at(input logic [TABLE_W-1:0] tbl,
                                                   input logic [3:0] idx);
      symbol_at = tbl[{idx, 3'b000} +: CHAR_W];
   endfunction

endpackage

// ===== rtl/signed_radix_to_symbols_unit.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_symbols_unit
// writes a signed integer as text, a minus sign when negative, then digits, in a configured alphabet
// each digit comes from a long division by the radix over C = ceil(VALUE_BITS/8)
// chunks, done by the 8 bit per cycle radix divider; the minus sign, if any, and
// then the digits, most significant first, leave on the one word per cycle output;
// the receiver cannot stall, and start is ignored while busy
// reset and every csr write run an alphabet check of all MAX_SYMBOLS entries, busy high
// ----------------------------------------------------------------------------
module signed_radix_to_symbols_unit #(
   parameter int MAX_SYMBOLS = srsym_pkg::MAX_SYMBOLS_DEF,
   parameter int VALUE_BITS  = srsym_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [VALUE_BITS-1:0]          req_value,
   output logic                                  rsp_strobe,
   output logic [srsym_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                  rsp_last_char,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srsym_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [srsym_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int STEP   = srsym_pkg::STEP_BITS;
   localparam int CHUNKS = (VALUE_BITS + STEP - 1) / STEP;
   localparam int QW     = CHUNKS * STEP;
   localparam int CHK_W  = $clog2(MAX_SYMBOLS);
   localparam int DIG_W  = $clog2(MAX_SYMBOLS);
   localparam int CNT_W  = $clog2(CHUNKS + 1);
   localparam int NDIG_W = $clog2(VALUE_BITS + 1);
   localparam int BLW    = srsym_pkg::BASE_LEN_W;

   srsym_pkg::state_type state_ff, state_in;

   logic [BLW-1:0]                   radix_ff, radix_in;
   logic [srsym_pkg::CSR_DATA_W-1:0] sym_low_ff, sym_low_in;
   logic [srsym_pkg::CSR_DATA_W-1:0] sym_high_ff, sym_high_in;

   logic             ok_ff, ok_in;
   logic [CHK_W-1:0] chk_idx_ff, chk_idx_in;

   logic [QW-1:0]     work_ff, work_in;
   logic [BLW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  chunk_ff, chunk_in;
   logic              qnz_ff, qnz_in;
   logic              neg_ff, neg_in;
   logic [NDIG_W-1:0] ndig_ff, ndig_in;
   logic [DIG_W-1:0]  stack_ff [VALUE_BITS];
   logic [DIG_W-1:0]  stack_in [VALUE_BITS];

   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [srsym_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [srsym_pkg::TABLE_W-1:0] table_w;
   logic [VALUE_BITS-1:0]         raw_w;
   logic [VALUE_BITS-1:0]         mag_w;

   assign table_w = {sym_high_ff, sym_low_ff};
   assign raw_w   = $unsigned(req_value);
   assign mag_w   = raw_w[VALUE_BITS-1] ? (~raw_w + 1'b1) : raw_w;

   assign busy          = (state_ff != srsym_pkg::ST_IDLE);
   assign csr_ready     = ((state_ff == srsym_pkg::ST_IDLE) && !start) ||
                          (state_ff == srsym_pkg::ST_CHECK);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   always_comb begin
      logic [srsym_pkg::CHAR_W-1:0] sym;
      logic                         bad;
      logic [BLW-1:0]               r;
      logic [STEP-1:0]              top;
      logic [STEP-1:0]              qb;

      state_in      = state_ff;
      radix_in      = radix_ff;
      sym_low_in    = sym_low_ff;
      sym_high_in   = sym_high_ff;
      ok_in         = ok_ff;
      chk_idx_in    = chk_idx_ff;
      work_in       = work_ff;
      rem_in        = rem_ff;
      chunk_in      = chunk_ff;
      qnz_in        = qnz_ff;
      neg_in        = neg_ff;
      ndig_in       = ndig_ff;
      stack_in      = stack_ff;
      rsp_strobe_in = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;

      // alphabet check, one symbol per cycle against all later ones below the radix
      sym = srsym_pkg::symbol_at(table_w, 4'(chk_idx_ff));
      bad = (radix_ff < srsym_pkg::MIN_RADIX) || (radix_ff > BLW'(MAX_SYMBOLS));
      if (BLW'(chk_idx_ff) < radix_ff) begin
         if (sym == srsym_pkg::CHAR_MINUS || sym == srsym_pkg::CHAR_PLUS) begin
            bad = 1'b1;
         end
         for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if (BLW'(j) > BLW'(chk_idx_ff) && BLW'(j) < radix_ff &&
                srsym_pkg::symbol_at(table_w, 4'(j)) == sym) begin
               bad = 1'b1;
            end
         end
      end

      // one chunk of the long division by the radix
      r   = rem_ff;
      top = work_ff[QW-1 -: STEP];
      qb  = '0;
      for (int b = 0; b < STEP; b++) begin
         r = {r[BLW-2:0], top[STEP-1-b]};
         if (r >= radix_ff) begin
            r             = r - radix_ff;
            qb[STEP-1-b]  = 1'b1;
         end
      end

      unique case (state_ff)
         srsym_pkg::ST_CHECK: begin
            ok_in      = ok_ff & ~bad;
            chk_idx_in = chk_idx_ff + 1'b1;
            if (chk_idx_ff == CHK_W'(MAX_SYMBOLS - 1)) begin
               state_in = srsym_pkg::ST_IDLE;
            end
         end
         srsym_pkg::ST_IDLE: begin
            if (start && ok_ff) begin
               work_in  = QW'(mag_w);
               neg_in   = raw_w[VALUE_BITS-1];
               rem_in   = '0;
               chunk_in = '0;
               qnz_in   = 1'b0;
               ndig_in  = '0;
               state_in = srsym_pkg::ST_DIVIDE;
            end
         end
         srsym_pkg::ST_DIVIDE: begin
            work_in  = (work_ff << STEP) | QW'(qb);
            rem_in   = r;
            qnz_in   = qnz_ff | (|qb);
            chunk_in = chunk_ff + 1'b1;
            if (chunk_ff == CNT_W'(CHUNKS - 1)) begin
               stack_in[0] = r[DIG_W-1:0];
               for (int i = 1; i < VALUE_BITS; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               ndig_in  = ndig_ff + 1'b1;
               rem_in   = '0;
               chunk_in = '0;
               qnz_in   = 1'b0;
               if (!(qnz_ff | (|qb))) begin
                  state_in = neg_ff ? srsym_pkg::ST_SIGN : srsym_pkg::ST_EMIT;
               end
            end
         end
         srsym_pkg::ST_SIGN: begin
            rsp_strobe_in = 1'b1;
            rsp_char_in   = srsym_pkg::CHAR_MINUS;
            rsp_last_in   = 1'b0;
            state_in      = srsym_pkg::ST_EMIT;
         end
         srsym_pkg::ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_char_in   = srsym_pkg::symbol_at(table_w, 4'(stack_ff[0]));
            rsp_last_in   = (ndig_ff == NDIG_W'(1));
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
               stack_in[i] = stack_ff[i+1];
            end
            ndig_in = ndig_ff - 1'b1;
            if (ndig_ff == NDIG_W'(1)) begin
               state_in = srsym_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srsym_pkg::ST_CHECK;
         end
      endcase

      // register write restarts the alphabet check
      if (csr_valid && csr_ready) begin
         unique case (srsym_pkg::csr_index_type'(csr_index))
            srsym_pkg::CSR_BASE_LENGTH:  radix_in    = csr_wdata[BLW-1:0];
            srsym_pkg::CSR_SYMBOLS_LOW:  sym_low_in  = csr_wdata;
            srsym_pkg::CSR_SYMBOLS_HIGH: sym_high_in = csr_wdata;
            default:                     radix_in    = radix_ff;
         endcase
         ok_in      = 1'b1;
         chk_idx_in = '0;
         state_in   = srsym_pkg::ST_CHECK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srsym_pkg::ST_CHECK;
         radix_ff      <= srsym_pkg::BASE_LEN_RST;
         sym_low_ff    <= srsym_pkg::SYMBOLS_LOW_RST;
         sym_high_ff   <= srsym_pkg::SYMBOLS_HIGH_RST;
         ok_ff         <= 1'b1;
         chk_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_ff      <= radix_in;
         sym_low_ff    <= sym_low_in;
         sym_high_ff   <= sym_high_in;
         ok_ff         <= ok_in;
         chk_idx_ff    <= chk_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      rem_ff      <= rem_in;
      chunk_ff    <= chunk_in;
      qnz_ff      <= qnz_in;
      neg_ff      <= neg_in;
      ndig_ff     <= ndig_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
